>>> hdl/rdst_pkg.sv
// Shared types, codes and helpers for the random depth-first spanning tree walk.
// Used by the configuration registers, the shared divider and the top level.
// Depends on nothing.
package rdst_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int DIM_W     = 7;
  localparam int RND_W     = 31;
  localparam int CELL_W    = 12;
  localparam int DEPTH_W   = 13;
  localparam int DIV_CNT_W = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(64);

  // Visited bits are kept as epoch marks; zero never marks a visited cell.
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_STEP    = 1'b1;

  // Register index as seen on address bit 2.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [1:0] DIR_TOP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_BOTTOM = 2'd2;
  localparam logic [1:0] DIR_LEFT   = 2'd3;

  typedef enum logic [1:0] {
    KIND_CARVED    = 2'd0,
    KIND_BACKTRACK = 2'd1,
    KIND_FINISHED  = 2'd2,
    KIND_RESTARTED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic                 start;
    logic [RND_W-1:0]     dividend;
    logic [DIM_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RND_W-1:0] quotient;
    logic [DIM_W-1:0] remainder;
  } div_rsp_t;

  // Zero counts as one; anything above the grid limit saturates to it.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int limit);
    logic [DIM_W-1:0] r;
    begin
      r = v;
      if (v == '0) begin
        r = DIM_W'(1);
      end else if (int'(v) > limit) begin
        r = DIM_W'(limit);
      end
      return r;
    end
  endfunction

endpackage

>>> hdl/rdst_div.sv
// Shared restoring divider, one quotient bit per cycle, MSB first.
// Splits the top cell index into column and row by the grid width in use.
// Depends on rdst_pkg.
module rdst_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdst_pkg::div_req_t req_i,
  output rdst_pkg::div_rsp_t rsp_o
);
  import rdst_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0]     rem_q, rem_d;
  logic [RND_W-1:0]     quo_q, quo_d;
  logic [DIM_W-1:0]     dvs_q, dvs_d;
  logic [DIM_W:0]       trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[RND_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits back in DIM_W bits.
      rem_d = fits ? DIM_W'(trial - {1'b0, dvs_q}) : trial[DIM_W-1:0];
      quo_d = {quo_q[RND_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> hdl/rdst_cfg.sv
// Grid geometry registers behind the APB-style configuration port.
// Delivers the clamped width and height in use. Depends on rdst_pkg.
module rdst_cfg #(
  parameter int MAX_COLUMNS = rdst_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = rdst_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdst_pkg::APB_AW-1:0] paddr,
  input  logic [rdst_pkg::APB_DW-1:0] pwdata,
  output logic [rdst_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output rdst_pkg::geom_t             geom_o
);
  import rdst_pkg::*;

  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        width_d = pwdata[DIM_W-1:0];
      end else begin
        height_d = pwdata[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_RESET;
      height_q <= GRID_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? APB_DW'(height_q) : APB_DW'(width_q);

  assign geom_o.w = clamp_dim(width_q, MAX_COLUMNS);
  assign geom_o.h = clamp_dim(height_q, MAX_ROWS);

endmodule

>>> hdl/random_dfs_spanning_tree_walk.sv
// A restart reports from the restart state, after the clearing sweep if the epoch wraps; a step
// on an empty stack reports in the next cycle; other steps split the stack top into column and
// row in the shared divider, read the neighbor marks, then report a backtrack or a carved edge.
// Throughput: one item at a time; busy stays high until its result is shown, no stalls.
// Reset: a sweep over all MAX_COLUMNS*MAX_ROWS cells clears the visited store; the same sweep runs
// ahead of the sixteenth restart after reset and every fifteenth after, when the epoch wraps.
module random_dfs_spanning_tree_walk #(
  parameter int MAX_COLUMNS = rdst_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = rdst_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rdst_pkg::APB_AW-1:0]  paddr,
  input  logic [rdst_pkg::APB_DW-1:0]  pwdata,
  output logic [rdst_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [rdst_pkg::RND_W-1:0]   random_value_i,
  output logic                         done_o,
  output logic [1:0]                   kind_o,
  output logic [rdst_pkg::CELL_W-1:0]  from_cell_o,
  output logic [rdst_pkg::CELL_W-1:0]  to_cell_o,
  output logic [1:0]                   direction_o,
  output logic [rdst_pkg::DEPTH_W-1:0] stack_depth_o
);
  import rdst_pkg::*;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int CIW        = $clog2(CELL_COUNT);
  localparam int CNTW       = $clog2(CELL_COUNT + 1);
  localparam int CMPW       = (CIW + 1 > DIM_W + 1) ? CIW + 1 : DIM_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_RESTART = 4'd2;
  localparam logic [3:0] S_TOP     = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_NBR     = 4'd5;
  localparam logic [3:0] S_PICK    = 4'd6;
  localparam logic [3:0] S_CARVE   = 4'd8;

  geom_t    geom;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [3:0]         state_q, state_d;
  logic [CIW-1:0]     clr_q, clr_d;
  logic               rst_pend_q, rst_pend_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [2:0]         idx_q, idx_d;
  logic [CIW-1:0]     top_q, top_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic [CIW-1:0]     cand_q [4];
  logic [CIW-1:0]     cand_d [4];
  logic [3:0]         ok_q, ok_d;
  logic [3:0]         free_q, free_d;
  logic [1:0]         pick_q, pick_d;

  logic               done_q, done_d;
  kind_e              kind_q, kind_d;
  logic [CELL_W-1:0]  from_q, from_d;
  logic [CELL_W-1:0]  to_q, to_d;
  logic [1:0]         dir_q, dir_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  logic [EPOCH_W-1:0] vis_mem [CELL_COUNT];
  logic               vis_we;
  logic [CIW-1:0]     vis_waddr;
  logic [EPOCH_W-1:0] vis_wdata;
  logic [CIW-1:0]     vis_raddr;
  logic [EPOCH_W-1:0] vis_rd_q;

  logic [CIW-1:0]     stk_mem [CELL_COUNT];
  logic               stk_we;
  logic [CIW-1:0]     stk_waddr;
  logic [CIW-1:0]     stk_wdata;
  logic [CIW-1:0]     stk_raddr;
  logic [CIW-1:0]     stk_rd_q;

  logic [CMPW-1:0]    x_c, y_c, w_c, h_c, top_c, one_c;
  logic [2:0]         n_free;
  logic               full;
  logic [1:0]         prev;
  logic [1:0]         seen;
  logic               found;
  logic [1:0]         sel;

  // Four is one modulo three, so the base-four digits sum to the same remainder.
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [31:0] p;
    logic [2:0]  l1 [8];
    logic [3:0]  l2 [4];
    logic [4:0]  l3 [2];
    logic [5:0]  s;
    logic [3:0]  t;
    logic [1:0]  r;
    begin
      p = 32'(v);
      for (int i = 0; i < 8; i++) begin
        l1[i] = 3'(p[4*i +: 2]) + 3'(p[4*i+2 +: 2]);
      end
      for (int i = 0; i < 4; i++) begin
        l2[i] = 4'(l1[2*i]) + 4'(l1[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
        l3[i] = 5'(l2[2*i]) + 5'(l2[2*i+1]);
      end
      s = 6'(l3[0]) + 6'(l3[1]);
      t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
      if (t >= 4'd6) begin
        r = 2'(t - 4'd6);
      end else if (t >= 4'd3) begin
        r = 2'(t - 4'd3);
      end else begin
        r = t[1:0];
      end
      return r;
    end
  endfunction

  rdst_cfg #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom_o (geom)
  );

  rdst_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign busy = (state_q != S_IDLE);

  // Column and row of the top cell come out of the divider as remainder and quotient.
  assign x_c    = CMPW'(div_rsp.remainder);
  assign y_c    = CMPW'(div_rsp.quotient[CIW-1:0]);
  assign w_c    = CMPW'(geom.w);
  assign h_c    = CMPW'(geom.h);
  assign top_c  = CMPW'(top_q);
  assign one_c  = CMPW'(1);
  assign n_free = 3'($countones(free_q));
  assign full   = (cnt_q == CNTW'(CELL_COUNT));
  assign prev   = 2'(idx_q - 3'd1);

  assign stk_raddr = CIW'(cnt_q - CNTW'(1));
  assign vis_raddr = cand_q[idx_q[1:0]];

  // Slot of the pick_q-th open neighbor, in top, right, bottom, left order.
  always_comb begin
    seen  = '0;
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < 4; i++) begin
      if (free_q[i] && !found) begin
        if (seen == pick_q) begin
          sel   = 2'(i);
          found = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rst_pend_d = rst_pend_q;
    epoch_d    = epoch_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    top_d      = top_q;
    rnd_d      = rnd_q;
    cand_d     = cand_q;
    ok_d       = ok_q;
    free_d     = free_q;
    pick_d     = pick_q;
    done_d     = 1'b0;
    kind_d     = kind_q;
    from_d     = from_q;
    to_d       = to_q;
    dir_d      = dir_q;
    depth_d    = depth_q;
    vis_we     = 1'b0;
    vis_waddr  = '0;
    vis_wdata  = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    div_req    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (opcode_i == OP_RESTART) begin
            if (epoch_q == EPOCH_MAX) begin
              epoch_d    = EPOCH_W'(1);
              rst_pend_d = 1'b1;
              clr_d      = '0;
              state_d    = S_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
              state_d = S_RESTART;
            end
          end else if (cnt_q == '0) begin
            done_d  = 1'b1;
            kind_d  = KIND_FINISHED;
            from_d  = '0;
            to_d    = '0;
            dir_d   = DIR_TOP;
            depth_d = '0;
          end else begin
            rnd_d   = random_value_i;
            state_d = S_TOP;
          end
        end
      end
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        clr_d     = clr_q + CIW'(1);
        if (clr_q == CIW'(CELL_COUNT - 1)) begin
          rst_pend_d = 1'b0;
          state_d    = rst_pend_q ? S_RESTART : S_IDLE;
        end
      end
      S_RESTART: begin
        vis_we    = 1'b1;
        vis_wdata = epoch_q;
        stk_we    = 1'b1;
        cnt_d     = CNTW'(1);
        done_d    = 1'b1;
        kind_d    = KIND_RESTARTED;
        from_d    = '0;
        to_d      = '0;
        dir_d     = DIR_TOP;
        depth_d   = DEPTH_W'(1);
        state_d   = S_IDLE;
      end
      S_TOP: begin
        // Left-align the cell index so only CIW quotient bits are produced.
        top_d            = stk_rd_q;
        div_req.start    = 1'b1;
        div_req.dividend = RND_W'(stk_rd_q) << (RND_W - CIW);
        div_req.divisor  = geom.w;
        div_req.steps    = DIV_CNT_W'(CIW);
        state_d          = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ok_d[DIR_TOP]      = (y_c != '0) && (y_c - one_c < h_c);
          ok_d[DIR_RIGHT]    = (x_c + one_c < w_c) && (y_c < h_c);
          ok_d[DIR_BOTTOM]   = (y_c + one_c < h_c);
          ok_d[DIR_LEFT]     = (x_c != '0) && (y_c < h_c);
          cand_d[DIR_TOP]    = CIW'(top_c - w_c);
          cand_d[DIR_RIGHT]  = CIW'(top_c + one_c);
          cand_d[DIR_BOTTOM] = CIW'(top_c + w_c);
          cand_d[DIR_LEFT]   = CIW'(top_c - one_c);
          idx_d              = '0;
          state_d            = S_NBR;
        end
      end
      S_NBR: begin
        // One neighbor read per cycle; its mark comes back registered, in the next cycle.
        idx_d = idx_q + 3'd1;
        if (idx_q != '0) begin
          free_d[prev] = ok_q[prev] && (vis_rd_q != epoch_q);
        end
        if (idx_q == 3'd4) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if ((n_free == '0) || full) begin
          cnt_d   = cnt_q - CNTW'(1);
          done_d  = 1'b1;
          kind_d  = KIND_BACKTRACK;
          from_d  = CELL_W'(top_q);
          to_d    = '0;
          dir_d   = DIR_TOP;
          depth_d = DEPTH_W'(cnt_q - CNTW'(1));
          state_d = S_IDLE;
        end else if (n_free == 3'd3) begin
          pick_d  = mod3(rnd_q);
          state_d = S_CARVE;
        end else if (n_free == 3'd1) begin
          pick_d  = '0;
          state_d = S_CARVE;
        end else if (n_free == 3'd2) begin
          pick_d  = {1'b0, rnd_q[0]};
          state_d = S_CARVE;
        end else begin
          pick_d  = rnd_q[1:0];
          state_d = S_CARVE;
        end
      end
      S_CARVE: begin
        vis_we    = 1'b1;
        vis_waddr = cand_q[sel];
        vis_wdata = epoch_q;
        stk_we    = 1'b1;
        stk_waddr = CIW'(cnt_q);
        stk_wdata = cand_q[sel];
        cnt_d     = cnt_q + CNTW'(1);
        done_d    = 1'b1;
        kind_d    = KIND_CARVED;
        from_d    = CELL_W'(top_q);
        to_d      = CELL_W'(cand_q[sel]);
        dir_d     = sel;
        depth_d   = DEPTH_W'(cnt_q + CNTW'(1));
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      rst_pend_q <= 1'b0;
      epoch_q    <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      rst_pend_q <= rst_pend_d;
      epoch_q    <= epoch_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    rnd_q   <= rnd_d;
    cand_q  <= cand_d;
    ok_q    <= ok_d;
    free_q  <= free_d;
    pick_q  <= pick_d;
    kind_q  <= kind_d;
    from_q  <= from_d;
    to_q    <= to_d;
    dir_q   <= dir_d;
    depth_q <= depth_d;
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  assign done_o        = done_q;
  assign kind_o        = kind_q;
  assign from_cell_o   = from_q;
  assign to_cell_o     = to_q;
  assign direction_o   = dir_q;
  assign stack_depth_o = depth_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(CELL_COUNT))
    else $error("stack count exceeds the cell count");

  a_empty_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_STEP) && (cnt_q == '0))
      |=> (done_o && (kind_o == KIND_FINISHED)))
    else $error("step on an empty stack did not report finished");

  a_carve_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CARVE)
      |=> (done_o && (kind_o == KIND_CARVED) && (cnt_q == $past(cnt_q) + CNTW'(1))))
    else $error("carved edge without a matching push");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESTART) |=> (done_o && (cnt_q == CNTW'(1)) && (epoch_q != '0)))
    else $error("restart left a wrong stack or epoch");

endmodule

>>> bench/random_dfs_spanning_tree_walk_tb.sv
// Self-checking testbench for the random depth-first spanning tree walk.
// Drives walk commands and APB grid settings, predicts every walk report in step.
// Depends on rdst_pkg and random_dfs_spanning_tree_walk.
`timescale 1ns / 100ps

module random_dfs_spanning_tree_walk_tb;
  import rdst_pkg::*;

  localparam int          MAX_COLUMNS = DEF_MAX_COLUMNS;
  localparam int          MAX_ROWS    = DEF_MAX_ROWS;
  localparam int          CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    kind_e               kind;
    logic [CELL_W-1:0]   from_cell;
    logic [CELL_W-1:0]   to_cell;
    logic [1:0]          dir;
    logic [DEPTH_W-1:0]  depth;
  } walk_rpt_t;

  typedef struct {
    bit               is_reg;
    logic             reg_idx;
    logic [DIM_W-1:0] reg_val;
    logic             op;
    logic [RND_W-1:0] rnd;
    bit               typed;
    walk_rpt_t        want;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic                opcode_i;
  logic [RND_W-1:0]    random_value_i;
  logic                done_o;
  logic [1:0]          kind_o;
  logic [CELL_W-1:0]   from_cell_o;
  logic [CELL_W-1:0]   to_cell_o;
  logic [1:0]          direction_o;
  logic [DEPTH_W-1:0]  stack_depth_o;

  // Shadow of the walk: visited bits, path stack and grid registers.
  bit                  visited_q [CELLS];
  logic [CELL_W-1:0]   trail_q [CELLS];
  int unsigned         trail_len;
  logic [DIM_W-1:0]    cols_reg;
  logic [DIM_W-1:0]    rows_reg;

  walk_rpt_t           reports_due [$];
  script_row_t         script [$];
  walk_rpt_t           due_head;
  int unsigned         items_sent;
  int unsigned         mismatches;
  int unsigned         cycles;

  random_dfs_spanning_tree_walk #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .random_value_i(random_value_i),
    .done_o        (done_o),
    .kind_o        (kind_o),
    .from_cell_o   (from_cell_o),
    .to_cell_o     (to_cell_o),
    .direction_o   (direction_o),
    .stack_depth_o (stack_depth_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // One walk command applied to the shadow state; returns the report it causes.
  function automatic walk_rpt_t dfs_step(input logic op, input logic [RND_W-1:0] rnd);
    walk_rpt_t   r;
    int unsigned w, h, top, x, y, n, pick, i;
    int unsigned cand [4];
    logic [1:0]  cdir [4];
    r = '0;
    w = eff_dim(cols_reg, MAX_COLUMNS);
    h = eff_dim(rows_reg, MAX_ROWS);
    n = 0;
    if (op == OP_RESTART) begin
      for (i = 0; i < CELLS; i++) visited_q[i] = 1'b0;
      visited_q[0] = 1'b1;
      trail_q[0]   = '0;
      trail_len    = 1;
      r.kind  = KIND_RESTARTED;
      r.depth = DEPTH_W'(1);
      return r;
    end
    if (trail_len == 0) begin
      r.kind = KIND_FINISHED;
      return r;
    end
    top = trail_q[trail_len - 1];
    x = top % w;
    y = top / w;
    // The top cell may lie outside a grid that shrank mid-walk.
    if (y >= 1 && y - 1 < h && !visited_q[(y - 1) * w + x]) begin
      cand[n] = (y - 1) * w + x; cdir[n] = DIR_TOP; n++;
    end
    if (x + 1 < w && y < h && !visited_q[y * w + x + 1]) begin
      cand[n] = y * w + x + 1; cdir[n] = DIR_RIGHT; n++;
    end
    if (y + 1 < h && !visited_q[(y + 1) * w + x]) begin
      cand[n] = (y + 1) * w + x; cdir[n] = DIR_BOTTOM; n++;
    end
    if (x >= 1 && y < h && !visited_q[y * w + x - 1]) begin
      cand[n] = y * w + x - 1; cdir[n] = DIR_LEFT; n++;
    end
    r.from_cell = CELL_W'(top);
    if (n > 0 && trail_len < CELLS) begin
      pick = rnd % n;
      visited_q[cand[pick]] = 1'b1;
      trail_q[trail_len]    = CELL_W'(cand[pick]);
      trail_len++;
      r.kind    = KIND_CARVED;
      r.to_cell = CELL_W'(cand[pick]);
      r.dir     = cdir[pick];
    end else begin
      trail_len--;
      r.kind = KIND_BACKTRACK;
    end
    r.depth = DEPTH_W'(trail_len);
    return r;
  endfunction

  function automatic void add_step(input logic op, input logic [RND_W-1:0] rnd);
    script_row_t row;
    row = '{is_reg: 1'b0, reg_idx: 1'b0, reg_val: '0, op: op, rnd: rnd,
            typed: 1'b0, want: '0};
    script.insert(script.size(), row);
  endfunction

  function automatic void add_known(input logic op, input logic [RND_W-1:0] rnd,
                                    input kind_e kind, input int unsigned depth);
    script_row_t row;
    row = '{is_reg: 1'b0, reg_idx: 1'b0, reg_val: '0, op: op, rnd: rnd,
            typed: 1'b1, want: '0};
    row.want.kind  = kind;
    row.want.depth = DEPTH_W'(depth);
    script.insert(script.size(), row);
  endfunction

  function automatic void add_reg(input logic idx, input logic [DIM_W-1:0] val);
    script_row_t row;
    row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, op: OP_STEP, rnd: '0,
            typed: 1'b0, want: '0};
    script.insert(script.size(), row);
  endfunction

  task automatic send_item(input logic op, input logic [RND_W-1:0] rnd,
                           input bit typed, input walk_rpt_t want);
    walk_rpt_t pred;
    // Random gaps, except for a quiet stretch in the middle of the run.
    if (!(items_sent >= 600 && items_sent < 900) && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    random_value_i <= rnd;
    do @(posedge clk_i); while (busy);
    pred = dfs_step(op, rnd);
    reports_due.insert(reports_due.size(), typed ? want : pred);
    items_sent++;
  endtask

  // Grid registers only change once the block has drained.
  task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
    start <= 1'b0;
    while (reports_due.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(APB_DW - DIM_W)'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_GRID_WIDTH) cols_reg = val;
    else rows_reg = val;
  endtask

  task automatic log_miss(input string why, input walk_rpt_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want %s %0d->%0d dir %0d depth %0d", why, want.kind.name(),
               want.from_cell, want.to_cell, want.dir, want.depth);
      $display("  got kind %0d %0d->%0d dir %0d depth %0d", kind_o, from_cell_o,
               to_cell_o, direction_o, stack_depth_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (reports_due.size() == 0) begin
        log_miss("report with nothing pending", '0);
      end else begin
        due_head = reports_due.pop_front();
        if ({kind_o, from_cell_o, to_cell_o, direction_o, stack_depth_o} !== due_head)
          log_miss("walk report differs", due_head);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t      row;
    int unsigned      pick, steps, area, k;
    logic [DIM_W-1:0] w, h;
    logic             op;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    opcode_i       = OP_RESTART;
    random_value_i = '0;
    trail_len      = 0;
    cols_reg       = GRID_RESET;
    rows_reg       = GRID_RESET;
    items_sent     = 0;
    mismatches     = 0;
    cycles         = 0;
    for (k = 0; k < CELLS; k++) visited_q[k] = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes, both commands, grid corner cases.
    add_known(OP_STEP, '1, KIND_FINISHED, 0);
    add_known(OP_RESTART, '0, KIND_RESTARTED, 1);
    add_step(OP_STEP, '0);
    add_step(OP_STEP, '1);
    add_step(OP_STEP, RND_W'(2));
    add_step(OP_STEP, RND_W'(1));
    add_known(OP_RESTART, '1, KIND_RESTARTED, 1);
    add_step(OP_STEP, RND_W'(3));
    add_reg(REG_GRID_WIDTH, DIM_W'(1));
    add_reg(REG_GRID_HEIGHT, DIM_W'(1));
    add_known(OP_RESTART, '0, KIND_RESTARTED, 1);
    add_known(OP_STEP, '0, KIND_BACKTRACK, 0);
    add_known(OP_STEP, '0, KIND_FINISHED, 0);
    // A zero dimension behaves as one.
    add_reg(REG_GRID_WIDTH, '0);
    add_reg(REG_GRID_HEIGHT, '0);
    add_known(OP_RESTART, '0, KIND_RESTARTED, 1);
    add_known(OP_STEP, '1, KIND_BACKTRACK, 0);
    add_known(OP_STEP, '1, KIND_FINISHED, 0);
    // Oversized dimensions saturate at the grid limit.
    add_reg(REG_GRID_WIDTH, '1);
    add_reg(REG_GRID_HEIGHT, '1);
    add_known(OP_RESTART, '0, KIND_RESTARTED, 1);
    add_step(OP_STEP, RND_W'(32'h5555_5555));
    add_step(OP_STEP, RND_W'(32'h2AAA_AAAA));
    add_step(OP_STEP, RND_W'(5));
    // Shrink the grid under a walk in progress.
    add_reg(REG_GRID_WIDTH, DIM_W'(3));
    add_step(OP_STEP, RND_W'(7));
    add_step(OP_STEP, RND_W'(8));
    add_step(OP_STEP, '0);
    add_reg(REG_GRID_HEIGHT, DIM_W'(2));
    add_step(OP_STEP, '1);
    add_step(OP_STEP, RND_W'(4));
    add_step(OP_STEP, RND_W'(6));

    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) write_reg(row.reg_idx, row.reg_val);
      else send_item(row.op, row.rnd, row.typed, row.want);
    end

    // Random walks: mostly small grids walked to completion, a few large or odd ones.
    k = items_sent + RANDOM_ITEMS;
    while (items_sent < k) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        w = DIM_W'($urandom_range(1, 8));
        h = DIM_W'($urandom_range(1, 8));
      end else if (pick < 80) begin
        w = DIM_W'($urandom_range(1, 64));
        h = DIM_W'($urandom_range(1, 3));
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0: w = '0;
          1: w = DIM_W'(MAX_COLUMNS);
          2: w = '1;
          default: w = DIM_W'($urandom_range(65, 126));
        endcase
        h = DIM_W'($urandom_range(1, 6));
        if ($urandom_range(1)) {w, h} = {h, w};
      end else begin
        w = DIM_W'($urandom_range(0, 127));
        h = DIM_W'($urandom_range(0, 127));
      end
      write_reg(REG_GRID_WIDTH, w);
      if ($urandom_range(99) >= 15) write_reg(REG_GRID_HEIGHT, h);
      // Now and then keep the old walk going on the new grid.
      if ($urandom_range(99) < 85) send_item(OP_RESTART, RND_W'($urandom()), 1'b0, '0);
      area  = eff_dim(cols_reg, MAX_COLUMNS) * eff_dim(rows_reg, MAX_ROWS);
      steps = 2 * area + $urandom_range(0, 3);
      if (steps > 120) steps = $urandom_range(20, 120);
      repeat (steps) begin
        op = ($urandom_range(99) < 3) ? OP_RESTART : OP_STEP;
        send_item(op, RND_W'($urandom()), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
